// ===== design/poc_pkg.sv =====
// ----------------------------------------------------------------------------
// poc_pkg
// Shared constants, opcodes and types of the pattern occurrence counter.
// ----------------------------------------------------------------------------
package poc_pkg;

  localparam int MAX_PATTERN_DEF = 64;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 6;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int COUNT_W  = 32;

  localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TEXT  = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd1;

  typedef struct packed {
    logic              shift_en;
    logic              cmp_en;
    logic [BYTE_W-1:0] load_data;
  } cell_ctrl_t;

endpackage

// ===== design/poc_if.sv =====
// ----------------------------------------------------------------------------
// poc_if
// Valid/ready channels of the pattern occurrence counter.
// ----------------------------------------------------------------------------
interface poc_in_if;
  logic                         valid;
  logic                         ready;
  logic [poc_pkg::OPCODE_W-1:0] opcode;
  logic [poc_pkg::INDEX_W-1:0]  pattern_index;
  logic [poc_pkg::BYTE_W-1:0]   data_byte;
  logic                         last_byte;

  modport source (output valid, opcode, pattern_index, data_byte, last_byte, input ready);
  modport sink   (input valid, opcode, pattern_index, data_byte, last_byte, output ready);
endinterface

interface poc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        match_found;
  logic [poc_pkg::COUNT_W-1:0] match_count;
  logic                        count_final;

  modport source (output valid, match_found, match_count, count_final, input ready);
  modport sink   (input valid, match_found, match_count, count_final, output ready);
endinterface

interface poc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [poc_pkg::LEN_W-1:0] pattern_length;

  modport source (output valid, pattern_length, input ready);
  modport sink   (input valid, pattern_length, output ready);
endinterface

// ===== design/poc_cell.sv =====
// ----------------------------------------------------------------------------
// poc_cell
// One window position: holds a text byte and a pattern byte, passes the text
// byte to the next older position and registers its compare result.
// ----------------------------------------------------------------------------
module poc_cell (
  input  logic                        clk,
  input  poc_pkg::cell_ctrl_t         ctrl,
  input  logic                        load_en,
  input  logic [poc_pkg::BYTE_W-1:0]  win_in,
  input  logic [poc_pkg::BYTE_W-1:0]  ref_byte,
  input  logic                        active,
  output logic [poc_pkg::BYTE_W-1:0]  win_out,
  output logic [poc_pkg::BYTE_W-1:0]  pat_out,
  output logic                        hit
);
  import poc_pkg::*;

  logic [BYTE_W-1:0] win_r;
  logic [BYTE_W-1:0] pat_r;
  logic              hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      win_r <= win_in;
    end
    if (load_en) begin
      pat_r <= ctrl.load_data;
    end
    if (ctrl.cmp_en) begin
      hit_r <= !active || (win_r == ref_byte);
    end
  end

  assign win_out = win_r;
  assign pat_out = pat_r;
  assign hit     = hit_r;

endmodule

// ===== design/poc_align.sv =====
// ----------------------------------------------------------------------------
// poc_align
// Lines the pattern up with the window: position k gets pattern byte
// len-1-k, via a log shifter over the reversed pattern.
// ----------------------------------------------------------------------------
module poc_align #(
  parameter int MAX_PATTERN = poc_pkg::MAX_PATTERN_DEF,
  parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic [MAX_PATTERN*poc_pkg::BYTE_W-1:0] pat_flat,
  input  logic [LW-1:0]                          eff_len,
  output logic [MAX_PATTERN*poc_pkg::BYTE_W-1:0] aligned_flat,
  output logic [MAX_PATTERN-1:0]                 active
);
  import poc_pkg::*;

  localparam int SHW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int VW  = MAX_PATTERN * BYTE_W;

  logic [LW-1:0]  diff;
  logic [SHW-1:0] sh;
  logic [VW-1:0]  stg [SHW+1];

  assign diff = LW'(MAX_PATTERN) - eff_len;
  assign sh   = diff[SHW-1:0];

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      stg[0][j*BYTE_W +: BYTE_W] = pat_flat[(MAX_PATTERN-1-j)*BYTE_W +: BYTE_W];
    end
    for (int s = 0; s < SHW; s++) begin
      stg[s+1] = sh[s] ? (stg[s] >> (BYTE_W * (1 << s))) : stg[s];
    end
  end

  assign aligned_flat = stg[SHW];

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_act
      assign active[k] = (LW'(k) < eff_len);
    end
  endgenerate

endmodule

// ===== design/pattern_occurrence_counter.sv =====
// ----------------------------------------------------------------------------
// pattern_occurrence_counter
// Counts overlapping occurrences of a stored byte pattern in a byte stream.
//
// Channels: in_word carries one command word (start, pattern load or text
// byte); out_word returns exactly one result word per command word, in order;
// cfg_word writes pattern_length and is always ready.
// A text byte passes a shift, a compare and a count step: the byte shifts
// into the window cells, the cells compare against the aligned pattern and
// register their hits, then the hits are reduced and the 32-bit count is
// updated. Throughput: 1 word/cycle for start and load while the output
// slot is free or read; a new text byte only once the last one is counted.
// Results sit in an output register: a text word is accepted while a result
// waits, a start or load word only when the slot is free or read that cycle;
// a stalled receiver holds the text word in its final step and blocks
// further input until the slot frees.
// Reset: count and window fill cleared, pattern_length = 1, output empty.
// Pattern and window bytes are not reset.
// ----------------------------------------------------------------------------
module pattern_occurrence_counter #(
  parameter int MAX_PATTERN = poc_pkg::MAX_PATTERN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  poc_in_if.sink    in_word,
  poc_out_if.source out_word,
  poc_cfg_if.sink   cfg_word
);
  import poc_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int CW = (LW > LEN_W) ? LW : LEN_W;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_FIN} state_t;

  state_t               state_r;
  logic [LEN_W-1:0]     len_r;
  logic [LW-1:0]        fill_r;
  logic [COUNT_W-1:0]   cnt_r;
  logic                 last_r;
  logic                 ov_r;
  logic                 found_r;
  logic [COUNT_W-1:0]   cnt_out_r;
  logic                 final_r;

  logic                 in_fire;
  logic                 out_fire;
  logic                 fin_go;
  logic                 match;
  logic [COUNT_W-1:0]   cnt_inc;
  logic [CW-1:0]        len_ext;
  logic [LW-1:0]        eff_len;
  logic [LW-1:0]        fill_nxt;

  cell_ctrl_t                    ctrl;
  logic [MAX_PATTERN-1:0]        load_en;
  logic [MAX_PATTERN*BYTE_W-1:0] pat_flat;
  logic [MAX_PATTERN*BYTE_W-1:0] aligned_flat;
  logic [MAX_PATTERN*BYTE_W-1:0] win_flat;
  logic [MAX_PATTERN-1:0]        active;
  logic [MAX_PATTERN-1:0]        hit;

  assign len_ext = CW'(len_r);
  always_comb begin
    if (len_r == '0) begin
      eff_len = LW'(1);
    end else if (len_ext > CW'(MAX_PATTERN)) begin
      eff_len = LW'(MAX_PATTERN);
    end else begin
      eff_len = LW'(len_ext);
    end
  end

  assign in_word.ready  = (state_r == S_IDLE) &&
                          (!ov_r || out_word.ready || in_word.opcode == OP_TEXT);
  assign cfg_word.ready = 1'b1;
  assign in_fire  = in_word.valid && in_word.ready;
  assign out_fire = ov_r && out_word.ready;
  assign fin_go   = (state_r == S_FIN) && (!ov_r || out_word.ready);
  assign match    = (&hit) && (fill_r >= eff_len);
  assign cnt_inc  = (cnt_r == '1) ? cnt_r : cnt_r + COUNT_W'(1);
  assign fill_nxt = (fill_r == LW'(MAX_PATTERN)) ? fill_r : fill_r + LW'(1);

  assign ctrl.shift_en  = in_fire && (in_word.opcode == OP_TEXT);
  assign ctrl.cmp_en    = (state_r == S_CMP);
  assign ctrl.load_data = in_word.data_byte;

  poc_align #(.MAX_PATTERN(MAX_PATTERN), .LW(LW)) u_align (
    .pat_flat     (pat_flat),
    .eff_len      (eff_len),
    .aligned_flat (aligned_flat),
    .active       (active)
  );

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [BYTE_W-1:0] win_in;

      if (k == 0) begin : g_head
        assign win_in = in_word.data_byte;
      end else begin : g_link
        assign win_in = win_flat[(k-1)*BYTE_W +: BYTE_W];
      end

      // indexes past the chain match no cell and are dropped
      assign load_en[k] = in_fire && (in_word.opcode == OP_LOAD) &&
                          (32'(in_word.pattern_index) == k);

      poc_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .load_en  (load_en[k]),
        .win_in   (win_in),
        .ref_byte (aligned_flat[k*BYTE_W +: BYTE_W]),
        .active   (active[k]),
        .win_out  (win_flat[k*BYTE_W +: BYTE_W]),
        .pat_out  (pat_flat[k*BYTE_W +: BYTE_W]),
        .hit      (hit[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= LEN_RESET;
      fill_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_word.valid) begin
        len_r <= cfg_word.pattern_length;
      end
      if (out_fire) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_word.opcode)
              OP_START: begin
                cnt_r     <= '0;
                fill_r    <= '0;
                ov_r      <= 1'b1;
                found_r   <= 1'b0;
                cnt_out_r <= '0;
                final_r   <= 1'b0;
              end
              OP_TEXT: begin
                fill_r  <= fill_nxt;
                last_r  <= in_word.last_byte;
                state_r <= S_CMP;
              end
              default: begin
                ov_r      <= 1'b1;
                found_r   <= 1'b0;
                cnt_out_r <= cnt_r;
                final_r   <= 1'b0;
              end
            endcase
          end
        end
        S_CMP: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            ov_r      <= 1'b1;
            found_r   <= match;
            cnt_out_r <= match ? cnt_inc : cnt_r;
            final_r   <= last_r;
            cnt_r     <= match ? cnt_inc : cnt_r;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_word.valid       = ov_r;
  assign out_word.match_found = found_r;
  assign out_word.match_count = cnt_out_r;
  assign out_word.count_final = final_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(MAX_PATTERN))
    else $error("window fill above pattern maximum");

  a_cmp_after_text: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> $past(in_fire))
    else $error("compare step without an accepted text word");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && match) |=> (cnt_r == $past(cnt_inc)))
    else $error("count did not advance on a match");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_word.opcode == OP_START) |=> (cnt_r == '0 && fill_r == '0))
    else $error("start word did not clear count and fill");

endmodule

// ===== verif/tb_pattern_occurrence_counter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pattern_occurrence_counter
// Self-checking bench for the pattern occurrence counter. A scoreboard class
// keeps its own copy of the pattern store, the text window and the running
// count. It predicts one result word per accepted command word and compares
// every result word, field by field, in order. Stimulus starts with a short
// directed list. Random phases follow at several pattern lengths, including
// 0, 64 and 127, and under several idle and stall mixes. One phase has a long
// receiver hold-off, and in every phase the sender pauses until all results are in.
// ----------------------------------------------------------------------------
module tb_pattern_occurrence_counter;
  import poc_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_WORDS  = 113;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_PHASES   = 10;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  index;
    logic [BYTE_W-1:0]   data;
    logic                last;
  } cmd_word_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic               fin;
  } result_word_t;

  class occurrence_scoreboard;
    logic [BYTE_W-1:0]  pattern_store [MAX_PATTERN_DEF];
    logic [BYTE_W-1:0]  text_window [MAX_PATTERN_DEF];
    int unsigned        window_fill;
    logic [COUNT_W-1:0] running_total;
    logic [LEN_W-1:0]   length_reg;
    result_word_t       expected_q[$];
    int unsigned        errors;
    int unsigned        matches_expected;

    function void clear();
      foreach (pattern_store[i]) begin
        pattern_store[i] = '0;
        text_window[i]   = '0;
      end
      window_fill   = 0;
      running_total = '0;
      length_reg    = LEN_RESET;
      expected_q.delete();
    endfunction

    function int unsigned used_length();
      if (length_reg == 0) return 1;
      if (length_reg > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
      return length_reg;
    endfunction

    function void note_word(cmd_word_t w);
      result_word_t r;
      int unsigned  n;
      bit           hit;
      r = '0;
      case (w.opcode)
        OP_START: begin
          window_fill   = 0;
          running_total = '0;
        end
        OP_LOAD: pattern_store[w.index] = w.data;
        OP_TEXT: begin
          n = used_length();
          for (int k = MAX_PATTERN_DEF - 1; k > 0; k--) text_window[k] = text_window[k-1];
          text_window[0] = w.data;
          if (window_fill < MAX_PATTERN_DEF) window_fill++;
          hit = (window_fill >= n);
          for (int k = 0; k < n; k++) begin
            if (pattern_store[n-1-k] != text_window[k]) hit = 1'b0;
          end
          if (hit) begin
            r.found = 1'b1;
            matches_expected++;
            if (running_total != '1) running_total++;
          end
          r.fin = w.last;
        end
        default: ;
      endcase
      r.count = running_total;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 20) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_word(result_word_t got);
      result_word_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word with none expected: %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found)
        report_mismatch($sformatf("match_found %b, expected %b", got.found, want.found));
      if (got.count !== want.count)
        report_mismatch($sformatf("match_count %0d, expected %0d", got.count, want.count));
      if (got.fin !== want.fin)
        report_mismatch($sformatf("count_final %b, expected %b", got.fin, want.fin));
    endtask
  endclass

  logic clk;
  logic rst_n;

  poc_in_if  in_if();
  poc_out_if out_if();
  poc_cfg_if cfg_if();

  pattern_occurrence_counter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if),
    .cfg_word (cfg_if)
  );

  occurrence_scoreboard sb;
  bit          loaded [MAX_PATTERN_DEF];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_off;
  int unsigned cycle_count = 0;
  int unsigned phase_words;
  int unsigned total_words;
  int unsigned text_words;
  int unsigned cfg_writes;

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    result_word_t got;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.found = out_if.match_found;
      got.count = out_if.match_count;
      got.fin   = out_if.count_final;
      sb.check_word(got);
    end
  end

  function automatic cmd_word_t mk(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                                   logic [BYTE_W-1:0] d, logic l);
    cmd_word_t w;
    w.opcode = op;
    w.index  = idx;
    w.data   = d;
    w.last   = l;
    return w;
  endfunction

  task automatic sender_gap();
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_word(input cmd_word_t w);
    in_if.valid         <= 1'b1;
    in_if.opcode        <= w.opcode;
    in_if.pattern_index <= w.index;
    in_if.data_byte     <= w.data;
    in_if.last_byte     <= w.last;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    sb.note_word(w);
    if (w.opcode == OP_LOAD) loaded[w.index] = 1'b1;
    if (w.opcode != OP_UNUSED) begin
      phase_words++;
      total_words++;
    end
    if (w.opcode == OP_TEXT) text_words++;
    sender_gap();
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    wait_drained();
    cfg_if.valid          <= 1'b1;
    cfg_if.pattern_length <= v;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    sb.length_reg = v;
    cfg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  // one text stream: usually a start, pattern bytes, text seeded with copies
  task automatic run_sequence();
    int unsigned       n;
    int unsigned       target;
    int unsigned       asize;
    int unsigned       extra;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] sym;
    logic [BYTE_W-1:0] text_q[$];
    n = sb.used_length();
    case ($urandom_range(3))
      0: asize = 1;
      1: asize = 2;
      2: asize = 4;
      default: asize = 256;
    endcase
    base = BYTE_W'($urandom);
    if ($urandom_range(9) != 0)
      send_word(mk(OP_START, INDEX_W'($urandom), BYTE_W'($urandom), 1'($urandom)));
    for (int k = 0; k < n; k++) begin
      sym = base + BYTE_W'($urandom_range(asize - 1));
      if (!loaded[k] || $urandom_range(2) == 0)
        send_word(mk(OP_LOAD, INDEX_W'(k), sym, 1'($urandom)));
    end
    target = $urandom_range(4, n + 24);
    while (text_q.size() < target) begin
      if ($urandom_range(3) == 0) begin
        for (int k = 0; k < n; k++) text_q.push_back(sb.pattern_store[k]);
      end else if ($urandom_range(19) == 0) begin
        text_q.push_back(BYTE_W'($urandom));
      end else begin
        sym = base + BYTE_W'($urandom_range(asize - 1));
        text_q.push_back(sym);
      end
    end
    foreach (text_q[i]) begin
      if ($urandom_range(29) == 0)
        send_word(mk(OP_UNUSED, INDEX_W'($urandom), BYTE_W'($urandom), 1'($urandom)));
      if ($urandom_range(39) == 0)
        send_word(mk(OP_LOAD, INDEX_W'($urandom), BYTE_W'($urandom), 1'($urandom)));
      send_word(mk(OP_TEXT, INDEX_W'($urandom), text_q[i], i == text_q.size() - 1));
    end
    extra = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (extra) begin
      sym = base + BYTE_W'($urandom_range(asize - 1));
      send_word(mk(OP_TEXT, INDEX_W'($urandom), sym, 1'($urandom_range(1))));
    end
  endtask

  initial begin
    logic [LEN_W-1:0] phase_len [NUM_PHASES];
    int unsigned      seq;
    phase_len = '{7'd3, 7'd1, 7'd64, 7'd2, 7'd127, 7'd6, 7'd0, 7'd65, 7'd4, 7'd12};
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.opcode          = OP_START;
    in_if.pattern_index   = '0;
    in_if.data_byte       = '0;
    in_if.last_byte       = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.pattern_length = LEN_RESET;
    hold_off              = 1'b0;
    send_idle_pct         = 0;
    stall_pct             = 0;
    total_words           = 0;
    text_words            = 0;
    cfg_writes            = 0;
    sb = new();
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    send_word(mk(OP_UNUSED, 6'd63, 8'hff, 1'b1));
    send_word(mk(OP_START, 6'd0, 8'h00, 1'b0));
    send_word(mk(OP_LOAD, 6'd0, 8'haa, 1'b0));
    send_word(mk(OP_TEXT, 6'd0, 8'haa, 1'b0));
    send_word(mk(OP_TEXT, 6'd0, 8'h55, 1'b0));
    send_word(mk(OP_TEXT, 6'd0, 8'haa, 1'b1));
    send_word(mk(OP_TEXT, 6'd0, 8'haa, 1'b0));
    send_word(mk(OP_LOAD, 6'd1, 8'haa, 1'b1));
    write_length(7'd0);
    send_word(mk(OP_TEXT, 6'd0, 8'haa, 1'b0));
    write_length(7'd2);
    send_word(mk(OP_TEXT, 6'd0, 8'haa, 1'b0));
    send_word(mk(OP_START, 6'd0, 8'h00, 1'b0));
    send_word(mk(OP_TEXT, 6'd0, 8'haa, 1'b0));
    send_word(mk(OP_TEXT, 6'd0, 8'haa, 1'b0));
    send_word(mk(OP_TEXT, 6'd0, 8'haa, 1'b0));
    send_word(mk(OP_TEXT, 6'd0, 8'h00, 1'b0));
    send_word(mk(OP_LOAD, 6'd63, 8'h00, 1'b0));
    send_word(mk(OP_LOAD, 6'd0, 8'hff, 1'b0));
    send_word(mk(OP_TEXT, 6'd63, 8'hff, 1'b0));
    send_word(mk(OP_TEXT, 6'd0, 8'haa, 1'b1));
    send_word(mk(OP_START, 6'd63, 8'hff, 1'b1));

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_length(phase_len[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 65; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 65; end
        default: begin send_idle_pct = 11; stall_pct <= 11; end
      endcase
      if (p == 0) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      phase_words = 0;
      seq = 0;
      while (phase_words < PHASE_WORDS) begin
        if (seq == 2) wait_drained();
        run_sequence();
        seq++;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d result words never arrived", sb.expected_q.size()));
    $display("Covered %0d command words (%0d text bytes, %0d matches) over %0d length writes,",
             total_words, text_words, sb.matches_expected, cfg_writes);
    $display("with idle/stall mixes on both sides and a long receiver hold-off.");
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/poc_pkg.sv
design/poc_if.sv
design/poc_cell.sv
design/poc_align.sv
design/pattern_occurrence_counter.sv
verif/tb_pattern_occurrence_counter.sv
